// File: sv/epoch_seconds_to_calendar_date_macros.svh
// ----------------------------------------------------------------------------
// epoch seconds to calendar date: assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ECD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecd check failed");

// antecedent implies consequent in the next cycle
`define ECD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecd check failed");

`endif

// File: sv/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// field types and constant tables for the epoch to calendar converter
// ----------------------------------------------------------------------------
package ecd_pkg;

    typedef logic [31:0] epoch_t;
    typedef logic [11:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  mday_t;
    typedef logic [4:0]  hour_t;
    typedef logic [5:0]  minute_t;
    typedef logic [5:0]  second_t;

    // seconds per day is 2^7 * 675; reciprocal of 675 scaled by 2^35
    localparam logic [25:0] DAY_RECIP       = 26'd50903317;
    localparam int          DAY_SHIFT       = 35;
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;

    // days from 1968-01-01 to 1970-01-01, and day index of 2100-03-01 from 1970
    localparam logic [15:0] EPOCH_OFFSET    = 16'd731;
    localparam logic [15:0] EPOCH_OFFSET_P1 = 16'd732;
    localparam logic [15:0] SKIP_LEAP_DAY   = 16'd47541;

    // four-year cycle of 1461 days, reciprocal scaled by 2^26
    localparam logic [15:0] CYCLE_RECIP     = 16'd45934;
    localparam int          CYCLE_SHIFT     = 26;
    localparam logic [10:0] DAYS_PER_CYCLE  = 11'd1461;

    // seconds per hour is 2^4 * 225; reciprocal of 225 scaled by 2^20
    localparam logic [12:0] HOUR_RECIP      = 13'd4661;
    localparam int          HOUR_SHIFT      = 20;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;

    // seconds per minute is 2^2 * 15; reciprocal of 15 scaled by 2^14
    localparam logic [10:0] MIN_RECIP       = 11'd1093;
    localparam int          MIN_SHIFT       = 14;
    localparam logic [5:0]  SECS_PER_MIN    = 6'd60;

    localparam year_t       CYCLE_BASE_YEAR = 12'd1968;

    // first day of each month within the year, common and leap
    typedef logic [8:0] doy_t;
    typedef doy_t month_start_t [2][12];
    localparam month_start_t MONTH_START = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
          9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
    };

endpackage

// File: sv/ecd_in_if.sv
// ----------------------------------------------------------------------------
// ecd_in_if
// valid/ready channel carrying one epoch timestamp
// ----------------------------------------------------------------------------
interface ecd_in_if;

    logic            valid;
    logic            ready;
    ecd_pkg::epoch_t epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);

endinterface

// File: sv/ecd_out_if.sv
// ----------------------------------------------------------------------------
// ecd_out_if
// valid/ready channel carrying one calendar date and time of day
// ----------------------------------------------------------------------------
interface ecd_out_if;

    logic             valid;
    logic             ready;
    ecd_pkg::year_t   year;
    ecd_pkg::month_t  month;
    ecd_pkg::mday_t   day_of_month;
    ecd_pkg::hour_t   hour;
    ecd_pkg::minute_t minute;
    ecd_pkg::second_t second;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, output ready);

endinterface

// File: sv/epoch_seconds_to_calendar_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// unsigned seconds since 1970-01-01 00:00:00 to Gregorian date and time
// ----------------------------------------------------------------------------
// usage
//   epoch: one transfer carries epoch_seconds, a 32-bit unsigned count
//   date:  one transfer per input carrying year, month, day_of_month,
//          hour, minute and second, in input order
//   throughput: one timestamp per cycle while date.ready is high; the six stages are split at the
//          constant-reciprocal multipliers for day, cycle, hour and minute
//   each stage holds its own valid bit and loads whenever it is empty or
//   the stage after it moves, so bubbles close up during a stall
//   when date.ready is low a full pipeline holds every item in place and
//   epoch.ready drops; nothing is lost or repeated
//   reset empties the pipeline; the block keeps no other state
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_date_macros.svh"

module epoch_seconds_to_calendar_date (
    input  logic        clk,
    input  logic        rst_n,
    ecd_in_if.sink      epoch,
    ecd_out_if.source   date
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] rdy;

    // stage 1: whole days
    logic [50:0]      s1_prod;
    logic [15:0]      s1_days_reg;
    ecd_pkg::epoch_t  s1_secs_reg;

    // stage 2: seconds of day, days from 1968 with 2100 leap day inserted
    logic [31:0]      s2_sod_full;
    logic [15:0]      s2_d1_next;
    logic [15:0]      s2_d1_reg;
    logic [16:0]      s2_sod_reg;

    // stage 3: four-year cycle and hour
    logic [31:0]      s3_cprod;
    logic [25:0]      s3_hprod;
    logic [5:0]       s3_cyc_reg;
    logic [15:0]      s3_d1_reg;
    ecd_pkg::hour_t   s3_hour_reg;
    logic [16:0]      s3_sod_reg;

    // stage 4: day within cycle and seconds within hour
    logic [15:0]      s4_r_full;
    logic [16:0]      s4_rh_full;
    logic [10:0]      s4_r_reg;
    logic [5:0]       s4_cyc_reg;
    ecd_pkg::hour_t   s4_hour_reg;
    logic [11:0]      s4_remh_reg;

    // stage 5: year within cycle, day of year, minute
    logic [1:0]       s5_yy_next;
    logic [10:0]      s5_doy_full;
    logic [20:0]      s5_mprod;
    logic [1:0]       s5_yy_reg;
    ecd_pkg::doy_t    s5_doy_reg;
    logic [5:0]       s5_cyc_reg;
    ecd_pkg::hour_t   s5_hour_reg;
    ecd_pkg::minute_t s5_min_reg;
    logic [11:0]      s5_remh_reg;

    // stage 6: month, day, second, year
    logic             s6_leap;
    logic [3:0]       s6_midx;
    ecd_pkg::doy_t    s6_start;
    ecd_pkg::doy_t    s6_mday_full;
    logic [11:0]      s6_sec_full;
    ecd_pkg::year_t   s6_year_next;
    ecd_pkg::year_t   out_year_reg;
    ecd_pkg::month_t  out_month_reg;
    ecd_pkg::mday_t   out_mday_reg;
    ecd_pkg::hour_t   out_hour_reg;
    ecd_pkg::minute_t out_min_reg;
    ecd_pkg::second_t out_sec_reg;

    // per-stage ready
    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || date.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign epoch.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= epoch.valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1
    assign s1_prod = epoch.epoch_seconds[31:7] * ecd_pkg::DAY_RECIP;

    always_ff @(posedge clk)
    begin
        if (rdy[0] && epoch.valid)
        begin
            s1_days_reg <= s1_prod[ecd_pkg::DAY_SHIFT +: 16];
            s1_secs_reg <= epoch.epoch_seconds;
        end
    end

    // stage 2
    assign s2_sod_full = s1_secs_reg - 32'(s1_days_reg) * 32'(ecd_pkg::SECS_PER_DAY);
    assign s2_d1_next  = (s1_days_reg >= ecd_pkg::SKIP_LEAP_DAY)
                       ? s1_days_reg + ecd_pkg::EPOCH_OFFSET_P1
                       : s1_days_reg + ecd_pkg::EPOCH_OFFSET;

    always_ff @(posedge clk)
    begin
        if (rdy[1] && v_reg[0])
        begin
            s2_d1_reg  <= s2_d1_next;
            s2_sod_reg <= s2_sod_full[16:0];
        end
    end

    // stage 3
    assign s3_cprod = s2_d1_reg * ecd_pkg::CYCLE_RECIP;
    assign s3_hprod = s2_sod_reg[16:4] * ecd_pkg::HOUR_RECIP;

    always_ff @(posedge clk)
    begin
        if (rdy[2] && v_reg[1])
        begin
            s3_cyc_reg  <= s3_cprod[ecd_pkg::CYCLE_SHIFT +: 6];
            s3_d1_reg   <= s2_d1_reg;
            s3_hour_reg <= s3_hprod[ecd_pkg::HOUR_SHIFT +: 5];
            s3_sod_reg  <= s2_sod_reg;
        end
    end

    // stage 4
    assign s4_r_full  = s3_d1_reg - 16'(s3_cyc_reg) * 16'(ecd_pkg::DAYS_PER_CYCLE);
    assign s4_rh_full = s3_sod_reg - 17'(s3_hour_reg) * 17'(ecd_pkg::SECS_PER_HOUR);

    always_ff @(posedge clk)
    begin
        if (rdy[3] && v_reg[2])
        begin
            s4_r_reg    <= s4_r_full[10:0];
            s4_cyc_reg  <= s3_cyc_reg;
            s4_hour_reg <= s3_hour_reg;
            s4_remh_reg <= s4_rh_full[11:0];
        end
    end

    // stage 5
    always_comb
    begin
        if (s4_r_reg < 11'd366)
        begin
            s5_yy_next  = 2'd0;
            s5_doy_full = s4_r_reg;
        end
        else if (s4_r_reg < 11'd731)
        begin
            s5_yy_next  = 2'd1;
            s5_doy_full = s4_r_reg - 11'd366;
        end
        else if (s4_r_reg < 11'd1096)
        begin
            s5_yy_next  = 2'd2;
            s5_doy_full = s4_r_reg - 11'd731;
        end
        else
        begin
            s5_yy_next  = 2'd3;
            s5_doy_full = s4_r_reg - 11'd1096;
        end
    end

    assign s5_mprod = s4_remh_reg[11:2] * ecd_pkg::MIN_RECIP;

    always_ff @(posedge clk)
    begin
        if (rdy[4] && v_reg[3])
        begin
            s5_yy_reg   <= s5_yy_next;
            s5_doy_reg  <= s5_doy_full[8:0];
            s5_cyc_reg  <= s4_cyc_reg;
            s5_hour_reg <= s4_hour_reg;
            s5_min_reg  <= s5_mprod[ecd_pkg::MIN_SHIFT +: 6];
            s5_remh_reg <= s4_remh_reg;
        end
    end

    // stage 6
    assign s6_leap = (s5_yy_reg == 2'd0);

    always_comb
    begin
        s6_midx  = 4'd0;
        s6_start = ecd_pkg::MONTH_START[s6_leap][0];
        for (int m = 1; m < 12; m++)
        begin
            if (s5_doy_reg >= ecd_pkg::MONTH_START[s6_leap][m])
            begin
                s6_midx  = 4'(m);
                s6_start = ecd_pkg::MONTH_START[s6_leap][m];
            end
        end
    end

    assign s6_mday_full = s5_doy_reg - s6_start + 9'd1;
    assign s6_sec_full  = s5_remh_reg - 12'(s5_min_reg) * 12'(ecd_pkg::SECS_PER_MIN);
    assign s6_year_next = ecd_pkg::CYCLE_BASE_YEAR + 12'({s5_cyc_reg, 2'b00})
                        + 12'(s5_yy_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[5] && v_reg[4])
        begin
            out_year_reg  <= s6_year_next;
            out_month_reg <= s6_midx + 4'd1;
            out_mday_reg  <= s6_mday_full[4:0];
            out_hour_reg  <= s5_hour_reg;
            out_min_reg   <= s5_min_reg;
            out_sec_reg   <= s6_sec_full[5:0];
        end
    end

    assign date.valid        = v_reg[STAGES-1];
    assign date.year         = out_year_reg;
    assign date.month        = out_month_reg;
    assign date.day_of_month = out_mday_reg;
    assign date.hour         = out_hour_reg;
    assign date.minute       = out_min_reg;
    assign date.second       = out_sec_reg;

    `ECD_ASSERT_NEXT(a_input_lands, clk, rst_n, epoch.valid && epoch.ready, v_reg[0])
    `ECD_ASSERT_SAME(a_fields_in_range, clk, rst_n, date.valid,
        date.month >= 4'd1 && date.month <= 4'd12 && date.day_of_month >= 5'd1 &&
        date.hour <= 5'd23 && date.minute <= 6'd59 && date.second <= 6'd59)
    `ECD_ASSERT_SAME(a_february_length, clk, rst_n, date.valid && date.month == 4'd2,
        date.day_of_month <= 5'd29)
    `ECD_ASSERT_SAME(a_year_range, clk, rst_n, date.valid,
        date.year >= 12'd1970 && date.year <= 12'd2106)

endmodule
